/* design/iommu_remap_unit_register_file_top_assert.svh */
// assertion macros used by the register file checker
`ifndef IOMMU_REMAP_UNIT_REGISTER_FILE_TOP_ASSERT_SVH
`define IOMMU_REMAP_UNIT_REGISTER_FILE_TOP_ASSERT_SVH

// same-cycle implication
`define IRF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iommu_rf: same-cycle check failed");

// next-cycle implication
`define IRF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iommu_rf: next-cycle check failed");

`endif

/* design/iommu_rf_pkg.sv */
// shared types, register indexes and reset values of the remapping register file
package iommu_rf_pkg;

   localparam int REGS_PER_UNIT = 24;
   localparam int FIXED_REGS    = 20;
   localparam int MATCH_UNITS   = 2;
   localparam int REG_W         = 5;

   typedef logic [REG_W-1:0] reg_ix_type;

   localparam reg_ix_type IX_GCMD     = 5'd1;
   localparam reg_ix_type IX_GSTS     = 5'd2;
   localparam reg_ix_type IX_PMEN     = 5'd5;
   localparam reg_ix_type IX_CAP_LO   = 5'd8;
   localparam reg_ix_type IX_CAP_HI   = 5'd9;
   localparam reg_ix_type IX_ECAP_LO  = 5'd10;
   localparam reg_ix_type IX_CCMD_HI  = 5'd15;
   localparam reg_ix_type IX_IOTLB_LO = 5'd20;
   localparam reg_ix_type IX_IOTLB_HI = 5'd21;
   localparam reg_ix_type IX_IVA_LO   = 5'd22;
   localparam reg_ix_type IX_IVA_HI   = 5'd23;

   localparam logic CMD_WRITE = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_UNIT0_BASE   = 2'd0;
   localparam logic [1:0] CSR_UNIT1_BASE   = 2'd1;
   localparam logic [1:0] CSR_IOTLB_OFFSET = 2'd2;
   localparam logic [1:0] CSR_IVA_OFFSET   = 2'd3;

   // byte offsets of the fixed registers, in match priority order
   localparam logic [6:0] FIXED_OFF [FIXED_REGS] = '{
      7'h00, 7'h18, 7'h1C, 7'h34, 7'h38, 7'h64, 7'h68, 7'h6C, 7'h08, 7'h0C,
      7'h10, 7'h14, 7'h20, 7'h24, 7'h28, 7'h2C, 7'h70, 7'h74, 7'h78, 7'h7C
   };

   localparam logic [31:0] CAP_LO_RST     = 32'h2066_0462;
   localparam logic [31:0] CAP_HI_RST_U0  = 32'h00C0_0000;
   localparam logic [31:0] CAP_HI_RST_U1  = 32'h00D2_0080;
   localparam logic [31:0] ECAP_LO_RST_U0 = 32'h00F0_101A;
   localparam logic [31:0] ECAP_LO_RST_U1 = 32'h00F0_10DA;

   // result of the address decode
   typedef struct packed {
      logic       hit;
      logic       unit;
      reg_ix_type reg_ix;
   } dec_type;

   function automatic logic [31:0] reset_value(input logic unit, input reg_ix_type ix);
      logic [31:0] v;
      v = '0;
      unique case (ix)
         IX_CAP_LO:  v = CAP_LO_RST;
         IX_CAP_HI:  v = unit ? CAP_HI_RST_U1 : CAP_HI_RST_U0;
         IX_ECAP_LO: v = unit ? ECAP_LO_RST_U1 : ECAP_LO_RST_U0;
         default:    v = '0;
      endcase
      return v;
   endfunction

endpackage

/* design/iommu_rf_decode.sv */
// address decode against both unit windows with first-match priority
module iommu_rf_decode #(
   parameter int UNITS = 2
) (
   input  logic [31:0]           address,
   input  logic [31:0]           unit0_base,
   input  logic [31:0]           unit1_base,
   input  logic [11:0]           iotlb_offset,
   input  logic [11:0]           iva_offset,
   output iommu_rf_pkg::dec_type dec
);

   logic [31:0] diff [iommu_rf_pkg::MATCH_UNITS];
   logic [iommu_rf_pkg::REGS_PER_UNIT-1:0] match [iommu_rf_pkg::MATCH_UNITS];
   iommu_rf_pkg::reg_ix_type sel [iommu_rf_pkg::MATCH_UNITS];
   logic [12:0] iotlb_lo, iotlb_hi, iva_lo, iva_hi;
   logic        hit0, hit1;

   // address minus base wraps the same way base plus offset does
   assign diff[0] = address - unit0_base;
   assign diff[1] = address - unit1_base;

   assign iotlb_lo = {1'b0, iotlb_offset};
   assign iotlb_hi = {1'b0, iotlb_offset} + 13'd4;
   assign iva_lo   = {1'b0, iva_offset};
   assign iva_hi   = {1'b0, iva_offset} + 13'd4;

   always_comb begin
      for (int u = 0; u < iommu_rf_pkg::MATCH_UNITS; u++) begin
         for (int r = 0; r < iommu_rf_pkg::FIXED_REGS; r++) begin
            match[u][r] = diff[u] == 32'(iommu_rf_pkg::FIXED_OFF[r]);
         end
         match[u][iommu_rf_pkg::IX_IOTLB_LO] = diff[u] == 32'(iotlb_lo);
         match[u][iommu_rf_pkg::IX_IOTLB_HI] = diff[u] == 32'(iotlb_hi);
         match[u][iommu_rf_pkg::IX_IVA_LO]   = diff[u] == 32'(iva_lo);
         match[u][iommu_rf_pkg::IX_IVA_HI]   = diff[u] == 32'(iva_hi);
         if (u >= UNITS) begin
            match[u] = '0;
         end
         // lowest index wins
         sel[u] = '0;
         for (int r = iommu_rf_pkg::REGS_PER_UNIT - 1; r >= 0; r--) begin
            if (match[u][r]) begin
               sel[u] = iommu_rf_pkg::reg_ix_type'(r);
            end
         end
      end
   end

   assign hit0       = |match[0];
   assign hit1       = |match[1];
   assign dec.hit    = hit0 | hit1;
   assign dec.unit   = ~hit0 & hit1;
   assign dec.reg_ix = hit0 ? sel[0] : sel[1];

endmodule

/* design/iommu_rf_regs.sv */
// register storage with write side effects and registered read port
module iommu_rf_regs #(
   parameter int UNITS = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  write,
   input  iommu_rf_pkg::dec_type dec,
   input  logic [31:0]           write_data,
   output logic [31:0]           read_data
);

   localparam int LIVE   = (UNITS < iommu_rf_pkg::MATCH_UNITS) ? UNITS
                                                               : iommu_rf_pkg::MATCH_UNITS;
   localparam int DEPTH  = LIVE * iommu_rf_pkg::REGS_PER_UNIT;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [31:0]       mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [iommu_rf_pkg::MATCH_UNITS-1:0] gsts_ff;
   logic [ADDR_W-1:0] idx;
   logic [31:0]       wval;
   logic              do_write;

   logic [31:0] mem_q_ff, rst_q_ff;
   logic        valid_q_ff, gsts_sel_ff, gsts_q_ff;

   assign idx = dec.unit ? ADDR_W'(iommu_rf_pkg::REGS_PER_UNIT + int'(dec.reg_ix))
                         : ADDR_W'(dec.reg_ix);
   assign do_write = enable & dec.hit & (write == iommu_rf_pkg::CMD_WRITE);

   // write side effects
   always_comb begin
      wval = write_data;
      unique case (dec.reg_ix)
         iommu_rf_pkg::IX_PMEN: wval[0] = write_data[31];
         iommu_rf_pkg::IX_CCMD_HI: begin
            if (write_data[31]) begin
               wval[28] = write_data[30];
               wval[27] = write_data[29];
               wval[31] = 1'b0;
            end
         end
         iommu_rf_pkg::IX_IOTLB_HI: begin
            if (write_data[31]) begin
               wval[26] = write_data[29];
               wval[25] = write_data[28];
               wval[31] = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[idx] <= wval;
      end
      if (enable) begin
         mem_q_ff    <= mem[idx];
         valid_q_ff  <= valid_ff[idx];
         rst_q_ff    <= iommu_rf_pkg::reset_value(dec.unit, dec.reg_ix);
         gsts_sel_ff <= dec.reg_ix == iommu_rf_pkg::IX_GSTS;
         gsts_q_ff   <= gsts_ff[dec.unit];
      end
   end

   // gsts bit 31 lives apart so a gcmd write can set it in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         gsts_ff  <= '0;
      end else if (do_write) begin
         valid_ff[idx] <= 1'b1;
         if (dec.reg_ix == iommu_rf_pkg::IX_GSTS) begin
            gsts_ff[dec.unit] <= wval[31];
         end else if (dec.reg_ix == iommu_rf_pkg::IX_GCMD && wval[31]) begin
            gsts_ff[dec.unit] <= 1'b1;
         end
      end
   end

   always_comb begin
      read_data = valid_q_ff ? mem_q_ff : rst_q_ff;
      if (gsts_sel_ff) begin
         read_data[31] = gsts_q_ff;
      end
   end

endmodule

/* design/iommu_remap_unit_register_file_top.sv */
// top level of the dma-remapping unit register file, 32-bit bus view
// a transferred request passes the input register, then the result register, which drives response valid
// throughput: one access per cycle unless the response is stalled; decode, register read and write share one stage
// reset: synchronous, clears handshake state, register valid bits and the gsts status bits;
//   unwritten registers read their capability or zero reset value at once, no clearing pass
module iommu_remap_unit_register_file_top #(
   parameter int UNITS = 2
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [31:0] req_address,
   input  logic [31:0] req_write_data,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic [31:0] rsp_read_data,
   // configuration writes
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   localparam logic [31:0] UNIT0_BASE_RST   = 32'hFED9_0000;
   localparam logic [31:0] UNIT1_BASE_RST   = 32'hFED9_1000;
   localparam logic [11:0] IOTLB_OFFSET_RST = 12'h108;
   localparam logic [11:0] IVA_OFFSET_RST   = 12'h100;

   logic [31:0] unit0_base_ff, unit1_base_ff;
   logic [11:0] iotlb_offset_ff, iva_offset_ff;

   // input stage
   logic        s1_valid_ff;
   logic        s1_command_ff;
   logic [31:0] s1_address_ff, s1_write_data_ff;

   // result stage
   logic        rsp_valid_ff, rsp_hit_ff, rsp_rd_hit_ff;

   logic                  req_xfer, advance;
   iommu_rf_pkg::dec_type dec;
   logic [31:0]           regs_read_data;

   // the input stage moves on whenever the result stage is empty or being drained,
   // so the request side only stalls behind a stalled response
   assign advance   = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = s1_valid_ff & ~advance;
   assign req_xfer  = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit0_base_ff   <= UNIT0_BASE_RST;
         unit1_base_ff   <= UNIT1_BASE_RST;
         iotlb_offset_ff <= IOTLB_OFFSET_RST;
         iva_offset_ff   <= IVA_OFFSET_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            iommu_rf_pkg::CSR_UNIT0_BASE:   unit0_base_ff   <= csr_write_data;
            iommu_rf_pkg::CSR_UNIT1_BASE:   unit1_base_ff   <= csr_write_data;
            iommu_rf_pkg::CSR_IOTLB_OFFSET: iotlb_offset_ff <= csr_write_data[11:0];
            iommu_rf_pkg::CSR_IVA_OFFSET:   iva_offset_ff   <= csr_write_data[11:0];
            default: ;
         endcase
      end
   end

   // input register, payload captured on every transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_command_ff    <= req_command;
         s1_address_ff    <= req_address;
         s1_write_data_ff <= req_write_data;
      end
   end

   iommu_rf_decode #(
      .UNITS (UNITS)
   ) u_decode (
      .address      (s1_address_ff),
      .unit0_base   (unit0_base_ff),
      .unit1_base   (unit1_base_ff),
      .iotlb_offset (iotlb_offset_ff),
      .iva_offset   (iva_offset_ff),
      .dec          (dec)
   );

   // storage reads and writes on the same edge that loads the result stage
   iommu_rf_regs #(
      .UNITS (UNITS)
   ) u_regs (
      .clock      (clock),
      .reset      (reset),
      .enable     (advance),
      .write      (s1_command_ff),
      .dec        (dec),
      .write_data (s1_write_data_ff),
      .read_data  (regs_read_data)
   );

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff    <= dec.hit;
         rsp_rd_hit_ff <= dec.hit & (s1_command_ff != iommu_rf_pkg::CMD_WRITE);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   // misses and write hits return zero
   assign rsp_read_data = rsp_rd_hit_ff ? regs_read_data : '0;

endmodule

/* design/iommu_rf_checker.sv */
// port-level checker for the register file and its bind
`include "iommu_remap_unit_register_file_top_assert.svh"

module iommu_rf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_hit,
   input logic [31:0] rsp_read_data
);

   `IRF_ASSERT_NXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `IRF_ASSERT_NXT(a_data_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_read_data))
   `IRF_ASSERT_NXT(a_hit_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_hit))
   `IRF_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, rsp_read_data == 32'd0)
   `IRF_ASSERT_IMP(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

endmodule

bind iommu_remap_unit_register_file_top iommu_rf_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_hit       (rsp_hit),
   .rsp_read_data (rsp_read_data)
);
